[rtl/byte_frame_receiver_sum8_core_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the frame receiver.
// Shared checks, written against the clk / rst_n of the including module.
// ----------------------------------------------------------------------------
`ifndef BYTE_FRAME_RECEIVER_SUM8_CORE_ASSERT_SVH
`define BYTE_FRAME_RECEIVER_SUM8_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define BFRS8_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define BFRS8_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/bfrs8_pkg.sv]
// ----------------------------------------------------------------------------
// bfrs8_pkg
// Types and constants of the byte frame receiver with 8-bit additive sum.
// ----------------------------------------------------------------------------
package bfrs8_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned CFG_IDX_W = 1;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_PAYLOAD  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_END_GOOD = 2'd1;
  localparam logic [KIND_W-1:0] KIND_END_BAD  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_HDR  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_HDR = 1'd1;

  // Header reset values
  localparam logic [BYTE_W-1:0] FIRST_HDR_RST  = 8'hAA;
  localparam logic [BYTE_W-1:0] SECOND_HDR_RST = 8'hAF;

  // Parser phase
  typedef enum logic [5:0] {
    PH_HUNT1   = 6'b000001,
    PH_HUNT2   = 6'b000010,
    PH_FUNC    = 6'b000100,
    PH_LEN     = 6'b001000,
    PH_PAYLOAD = 6'b010000,
    PH_SUM     = 6'b100000
  } phase_t;

endpackage

[rtl/byte_frame_receiver_sum8_core.sv]
// ----------------------------------------------------------------------------
// byte_frame_receiver_sum8_core
// Parses header / function / length / payload / checksum frames from a byte
// stream, forwards payload bytes with their index and reports each frame end.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------------
//   in      | input     | in_valid / in_stall  | in_rx_byte
//   out     | output    | out_valid / out_stall| out_kind, out_func_code,
//           |           |                      | out_frame_length, out_byte_value,
//           |           |                      | out_byte_index
//   cfg     | input     | cfg_we               | cfg_idx, cfg_wdata
//
// One word per cycle sustained while the output is not stalled; an accepted word is
// captured in the input register, and its result is then loaded into the output register.
// Reset (synchronous, rst_n low) returns the parser to header hunting, clears
// the held fields and loads the header registers with 0xAA / 0xAF.
// A stalled output holds its word; the input register then holds too and
// in_stall rises only while it is full and cannot drain.
// ----------------------------------------------------------------------------
`include "byte_frame_receiver_sum8_core_assert.svh"

module byte_frame_receiver_sum8_core
  import bfrs8_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // input channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [BYTE_W-1:0]    in_rx_byte,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [KIND_W-1:0]    out_kind,
  output logic [BYTE_W-1:0]    out_func_code,
  output logic [BYTE_W-1:0]    out_frame_length,
  output logic [BYTE_W-1:0]    out_byte_value,
  output logic [BYTE_W-1:0]    out_byte_index,
  // configuration
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [BYTE_W-1:0]    cfg_wdata
);

  // Configuration registers
  logic [BYTE_W-1:0] first_hdr_r;
  logic [BYTE_W-1:0] second_hdr_r;

  // Input register
  logic              in_valid_r;
  logic [BYTE_W-1:0] in_byte_r;

  // Parser state
  phase_t            phase_r,   phase_nxt;
  logic [BYTE_W-1:0] func_r,    func_nxt;
  logic [BYTE_W-1:0] len_r,     len_nxt;
  logic [BYTE_W-1:0] cnt_r,     cnt_nxt;
  logic [BYTE_W-1:0] sum_r,     sum_nxt;

  // Result register
  logic              out_valid_r, res_valid_nxt;
  logic [KIND_W-1:0] kind_r,      kind_nxt;
  logic [BYTE_W-1:0] ofunc_r,     ofunc_nxt;
  logic [BYTE_W-1:0] olen_r,      olen_nxt;
  logic [BYTE_W-1:0] oval_r,      oval_nxt;
  logic [BYTE_W-1:0] oidx_r,      oidx_nxt;

  logic              out_free;
  logic              advance;
  logic              in_accept;
  logic [BYTE_W-1:0] sum_add;
  logic [BYTE_W-1:0] cnt_inc;

  // Handshake: the input word moves on when the result register can take it
  assign out_free  = !out_valid_r || !out_stall;
  assign advance   = in_valid_r && out_free;
  assign in_stall  = in_valid_r && !out_free;
  assign in_accept = in_valid && !in_stall;

  assign sum_add = sum_r + in_byte_r;
  assign cnt_inc = cnt_r + 8'd1;

  // Write header registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_hdr_r  <= FIRST_HDR_RST;
      second_hdr_r <= SECOND_HDR_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_FIRST_HDR:  first_hdr_r  <= cfg_wdata;
        CFG_SECOND_HDR: second_hdr_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Capture the input word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_accept) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_byte_r <= in_rx_byte;
    end
  end

  // Parse one word: next phase, held fields and the result it causes
  always_comb begin
    phase_nxt     = PH_HUNT1;
    func_nxt      = func_r;
    len_nxt       = len_r;
    cnt_nxt       = cnt_r;
    sum_nxt       = sum_r;
    res_valid_nxt = 1'b0;
    kind_nxt      = KIND_PAYLOAD;
    ofunc_nxt     = func_r;
    olen_nxt      = len_r;
    oval_nxt      = '0;
    oidx_nxt      = '0;
    unique case (phase_r)
      PH_HUNT2: begin
        // a mismatch drops back without retesting this word as a first header
        if (in_byte_r == second_hdr_r) begin
          sum_nxt   = sum_add;
          phase_nxt = PH_FUNC;
        end
      end
      PH_FUNC: begin
        func_nxt  = in_byte_r;
        sum_nxt   = sum_add;
        phase_nxt = PH_LEN;
      end
      PH_LEN: begin
        len_nxt   = in_byte_r;
        sum_nxt   = sum_add;
        cnt_nxt   = '0;
        phase_nxt = (in_byte_r == '0) ? PH_SUM : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        sum_nxt       = sum_add;
        res_valid_nxt = 1'b1;
        kind_nxt      = KIND_PAYLOAD;
        oval_nxt      = in_byte_r;
        oidx_nxt      = cnt_r;
        cnt_nxt       = cnt_inc;
        phase_nxt     = (cnt_inc == len_r) ? PH_SUM : PH_PAYLOAD;
      end
      PH_SUM: begin
        res_valid_nxt = 1'b1;
        kind_nxt      = (in_byte_r == sum_r) ? KIND_END_GOOD : KIND_END_BAD;
        cnt_nxt       = '0;
        sum_nxt       = '0;
        phase_nxt     = PH_HUNT1;
      end
      default: begin
        // hunt for the first header
        if (in_byte_r == first_hdr_r) begin
          sum_nxt   = in_byte_r;
          phase_nxt = PH_HUNT2;
        end
      end
    endcase
  end

  // Advance parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT1;
      func_r  <= '0;
      len_r   <= '0;
      cnt_r   <= '0;
      sum_r   <= '0;
    end else if (advance) begin
      phase_r <= phase_nxt;
      func_r  <= func_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
      sum_r   <= sum_nxt;
    end
  end

  // Load or drain the result register; hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= advance && res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid_nxt && out_free) begin
      kind_r  <= kind_nxt;
      ofunc_r <= ofunc_nxt;
      olen_r  <= olen_nxt;
      oval_r  <= oval_nxt;
      oidx_r  <= oidx_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = kind_r;
  assign out_func_code    = ofunc_r;
  assign out_frame_length = olen_r;
  assign out_byte_value   = oval_r;
  assign out_byte_index   = oidx_r;

  // Checks
  `BFRS8_ASSERT_NOW(a_payload_count_below_len, phase_r == PH_PAYLOAD, cnt_r != len_r,
    "payload phase reached with count equal to length")
  `BFRS8_ASSERT_NOW(a_end_fields_zero, out_valid_r && kind_r != KIND_PAYLOAD,
    oval_r == '0 && oidx_r == '0, "frame end word carries nonzero byte fields")
  `BFRS8_ASSERT_NEXT(a_stall_holds_input, in_stall, in_valid_r && $stable(in_byte_r),
    "input register lost its word under stall")

endmodule

[sim/frame_parse_checker.sv]
// ----------------------------------------------------------------------------
// Frame parse checker
// Watches the byte and result channels of the frame receiver, tracks the
// header registers and the parser state on its own, and compares every
// result word with the oldest expected one.
// ----------------------------------------------------------------------------
module frame_parse_checker
  import bfrs8_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [BYTE_W-1:0]    in_rx_byte,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [KIND_W-1:0]    out_kind,
  input  logic [BYTE_W-1:0]    out_func_code,
  input  logic [BYTE_W-1:0]    out_frame_length,
  input  logic [BYTE_W-1:0]    out_byte_value,
  input  logic [BYTE_W-1:0]    out_byte_index,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [BYTE_W-1:0]    cfg_wdata,
  output int                   fail_count,
  output int                   pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] func_code;
    logic [BYTE_W-1:0] frame_length;
    logic [BYTE_W-1:0] byte_value;
    logic [BYTE_W-1:0] byte_index;
  } frame_word_t;

  frame_word_t       expected_words[$];
  logic [BYTE_W-1:0] hdr_first;
  logic [BYTE_W-1:0] hdr_second;
  phase_t            parse_phase;
  logic [BYTE_W-1:0] func_held;
  logic [BYTE_W-1:0] len_held;
  logic [BYTE_W-1:0] payload_seen;
  logic [BYTE_W-1:0] frame_sum;
  int                mismatches = 0;

  // Advance the parser by one received byte and queue the word it yields
  task automatic parse_byte(input logic [BYTE_W-1:0] b);
    frame_word_t w;
    w.func_code    = func_held;
    w.frame_length = len_held;
    w.byte_value   = '0;
    w.byte_index   = '0;
    case (parse_phase)
      PH_HUNT2: begin
        if (b == hdr_second) begin
          frame_sum   = frame_sum + b;
          parse_phase = PH_FUNC;
        end else begin
          // the breaking byte is dropped, not retried as a first header
          parse_phase = PH_HUNT1;
        end
      end
      PH_FUNC: begin
        func_held   = b;
        frame_sum   = frame_sum + b;
        parse_phase = PH_LEN;
      end
      PH_LEN: begin
        len_held     = b;
        frame_sum    = frame_sum + b;
        payload_seen = '0;
        parse_phase  = (b == '0) ? PH_SUM : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        frame_sum    = frame_sum + b;
        w.kind       = KIND_PAYLOAD;
        w.byte_value = b;
        w.byte_index = payload_seen;
        expected_words.push_back(w);
        payload_seen = payload_seen + 1'b1;
        if (payload_seen == len_held) parse_phase = PH_SUM;
      end
      PH_SUM: begin
        w.kind = (b == frame_sum) ? KIND_END_GOOD : KIND_END_BAD;
        expected_words.push_back(w);
        parse_phase  = PH_HUNT1;
        payload_seen = '0;
        frame_sum    = '0;
      end
      default: begin
        if (b == hdr_first) begin
          frame_sum   = b;
          parse_phase = PH_HUNT2;
        end else begin
          parse_phase = PH_HUNT1;
        end
      end
    endcase
  endtask

  // Compare one accepted result word with the oldest expectation
  task automatic check_word();
    frame_word_t got;
    frame_word_t want;
    got.kind         = out_kind;
    got.func_code    = out_func_code;
    got.frame_length = out_frame_length;
    got.byte_value   = out_byte_value;
    got.byte_index   = out_byte_index;
    if (expected_words.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: unexpected word kind=%0d func=%h len=%0d value=%h index=%0d",
                 $time, got.kind, got.func_code, got.frame_length, got.byte_value,
                 got.byte_index);
    end else begin
      want = expected_words.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display({"%0t: word mismatch, expected kind=%0d func=%h len=%0d value=%h",
                    " index=%0d, got kind=%0d func=%h len=%0d value=%h index=%0d"},
                   $time, want.kind, want.func_code, want.frame_length, want.byte_value,
                   want.byte_index, got.kind, got.func_code, got.frame_length,
                   got.byte_value, got.byte_index);
      end
    end
  endtask

  // Follow register writes, accepted bytes and accepted result words
  always @(posedge clk) begin
    if (!rst_n) begin
      hdr_first    = FIRST_HDR_RST;
      hdr_second   = SECOND_HDR_RST;
      parse_phase  = PH_HUNT1;
      func_held    = '0;
      len_held     = '0;
      payload_seen = '0;
      frame_sum    = '0;
      expected_words.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_FIRST_HDR:  hdr_first  = cfg_wdata;
          CFG_SECOND_HDR: hdr_second = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) parse_byte(in_rx_byte);
      if (out_valid && !out_stall) check_word();
    end
    fail_count    <= mismatches;
    pending_count <= expected_words.size();
  end

endmodule

[sim/tb.sv]
// ----------------------------------------------------------------------------
// Frame receiver testbench
// Feeds directed and random byte streams (good frames, bad checksums, broken
// headers, truncated frames, line noise) under several header settings, with
// random gaps on the sender and random stalls on the result side.
// ----------------------------------------------------------------------------
module tb;
  import bfrs8_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_TARGET   = 1750;
  localparam int PHASE_ITEMS   = 290;
  localparam int SETTLE_CYCLES = 8;
  localparam int RUN_LIMIT_NS  = 1_000_000;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [BYTE_W-1:0]    in_rx_byte;
  logic                 out_valid;
  logic                 out_stall;
  logic [KIND_W-1:0]    out_kind;
  logic [BYTE_W-1:0]    out_func_code;
  logic [BYTE_W-1:0]    out_frame_length;
  logic [BYTE_W-1:0]    out_byte_value;
  logic [BYTE_W-1:0]    out_byte_index;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [BYTE_W-1:0]    cfg_wdata;

  int                   fail_count;
  int                   pending_count;
  bit                   send_gaps = 1'b1;
  bit                   recv_gaps = 1'b1;
  logic [BYTE_W-1:0]    hdr_a;
  logic [BYTE_W-1:0]    hdr_b;
  int                   bytes_sent = 0;
  int                   phase_sel;
  int                   phase_end;

  byte_frame_receiver_sum8_core DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_func_code    (out_func_code),
    .out_frame_length (out_frame_length),
    .out_byte_value   (out_byte_value),
    .out_byte_index   (out_byte_index),
    .cfg_we           (cfg_we),
    .cfg_idx          (cfg_idx),
    .cfg_wdata        (cfg_wdata)
  );

  frame_parse_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_func_code    (out_func_code),
    .out_frame_length (out_frame_length),
    .out_byte_value   (out_byte_value),
    .out_byte_index   (out_byte_index),
    .cfg_we           (cfg_we),
    .cfg_idx          (cfg_idx),
    .cfg_wdata        (cfg_wdata),
    .fail_count       (fail_count),
    .pending_count    (pending_count)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Offer one word after a random gap and hold it until it is taken
  task automatic put_byte(input logic [BYTE_W-1:0] b, input bit counted);
    int gap;
    gap = send_gaps ? $urandom_range(0, 19) : 0;
    repeat (gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (counted) bytes_sent++;
  endtask

  // Send a whole frame with random payload; optionally spoil the checksum
  task automatic send_frame(input logic [BYTE_W-1:0] func, input logic [BYTE_W-1:0] len,
                            input bit corrupt);
    logic [BYTE_W-1:0] sum;
    logic [BYTE_W-1:0] data;
    sum = hdr_a + hdr_b + func + len;
    put_byte(hdr_a, 1'b1);
    put_byte(hdr_b, 1'b1);
    put_byte(func, 1'b1);
    put_byte(len, 1'b1);
    for (int i = 0; i < len; i++) begin
      data = 8'($urandom);
      sum  = sum + data;
      put_byte(data, 1'b1);
    end
    if (corrupt) sum = sum ^ 8'($urandom_range(1, 255));
    put_byte(sum, 1'b1);
  endtask

  // Drop valid, wait for every expected word, then let the pipeline empty
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both header registers back to back
  task automatic set_headers(input logic [BYTE_W-1:0] first, input logic [BYTE_W-1:0] second);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_FIRST_HDR;
    cfg_wdata <= first;
    @(posedge clk);
    cfg_idx   <= CFG_SECOND_HDR;
    cfg_wdata <= second;
    @(posedge clk);
    cfg_we    <= 1'b0;
    hdr_a = first;
    hdr_b = second;
  endtask

  // Pick one random sequence: mostly good frames, some broken ones and noise
  task automatic random_sequence();
    int                pick;
    logic [BYTE_W-1:0] b;
    logic [BYTE_W-1:0] len;
    send_gaps = ($urandom_range(0, 3) != 0);
    recv_gaps = ($urandom_range(0, 3) != 0);
    pick = $urandom_range(0, 99);
    if (pick < 75) begin
      len = ($urandom_range(0, 39) == 0) ? 8'($urandom_range(0, 255))
                                         : 8'($urandom_range(0, 12));
      send_frame(8'($urandom), len, $urandom_range(0, 5) == 0);
    end else if (pick < 87) begin
      // wrong second header, sometimes a repeated first header
      put_byte(hdr_a, 1'b1);
      if ($urandom_range(0, 1) == 1 && hdr_a != hdr_b) begin
        b = hdr_a;
      end else begin
        b = 8'($urandom);
        while (b == hdr_b) b = 8'($urandom);
      end
      put_byte(b, 1'b1);
    end else if (pick < 92) begin
      // frame cut off after its function code
      put_byte(hdr_a, 1'b1);
      put_byte(hdr_b, 1'b1);
      put_byte(8'($urandom), 1'b1);
    end else begin
      repeat ($urandom_range(1, 4)) put_byte(8'($urandom), 1'b1);
    end
  endtask

  // Result side: stall a random number of cycles before each word
  initial begin
    int hold;
    out_stall = 1'b0;
    forever begin
      hold = recv_gaps ? $urandom_range(0, 19) : 0;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin
    #RUN_LIMIT_NS;
    $display("FAIL");
    $finish;
  end

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_rx_byte = '0;
    cfg_we     = 1'b0;
    cfg_idx    = CFG_FIRST_HDR;
    cfg_wdata  = '0;
    hdr_a      = FIRST_HDR_RST;
    hdr_b      = SECOND_HDR_RST;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty frame, broken second header, extremes, bad checksum
    send_frame(8'h00, 8'd0, 1'b0);
    put_byte(hdr_a, 1'b1);
    put_byte(hdr_a, 1'b1);
    put_byte(hdr_b, 1'b1);
    send_frame(8'hFF, 8'd2, 1'b0);
    send_frame(8'h5A, 8'd1, 1'b1);
    settle();

    // Random phases, each under its own header setting
    phase_sel = 0;
    while (bytes_sent < ITEM_TARGET) begin
      case (phase_sel % 6)
        0:       set_headers(8'h00, 8'hFF);
        1:       set_headers(8'hFF, 8'h00);
        2:       set_headers(8'h55, 8'h55);
        4:       set_headers(FIRST_HDR_RST, SECOND_HDR_RST);
        default: set_headers(8'($urandom), 8'($urandom));
      endcase
      phase_end = bytes_sent + PHASE_ITEMS;
      if (phase_sel == 3) send_frame(8'($urandom), 8'd255, 1'b0);
      while (bytes_sent < phase_end) random_sequence();
      settle();
      phase_sel++;
    end

    if (fail_count == 0 && pending_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
